// File: design/swle_pkg.sv
package swle_pkg;

	localparam int MAX_HALF_WINDOW_DEF = 15;
	localparam int SAMPLE_BITS_DEF     = 16;
	localparam int MAX_OUT             = 16;
	localparam int LOG_FRAC            = 24;
	// log2 of up to 127 window samples fits in 3 integer bits and LOG_FRAC fraction bits.
	localparam int LOG_W               = 27;
	localparam int LOG_ENTRIES         = 128;
	localparam int LOG_IDX_W           = 7;

	typedef enum logic [1:0] {
		CFG_HALF_WINDOW = 2'd0,
		CFG_NUM_CLASSES = 2'd1,
		CFG_MIN_COUNT   = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LOAD,
		ST_ROT,
		ST_TEST,
		ST_SUM,
		ST_MULA,
		ST_MULB,
		ST_DIVE_GO,
		ST_DIVE_WAIT,
		ST_DIVD_GO,
		ST_DIVD_WAIT,
		ST_OUT,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [15:0] sample;
		logic        sample_valid;
		logic        series_end;
	} in_t;

	typedef struct packed {
		logic [31:0] position;
		logic [15:0] entropy;
		logic [31:0] deviation;
		logic        not_available;
		logic        last_of_run;
	} out_t;

	typedef struct packed {
		logic shift;
		logic clear;
		logic load;
		logic rot;
		logic sum;
	} cell_ctl_t;

	typedef logic [LOG_W-1:0] log_tab_t [LOG_ENTRIES];

	function automatic logic [LOG_W-1:0] fixed_log2(input int unsigned k);
		int unsigned m;
		logic [63:0] x;
		logic [63:0] r;
		int b;
		m = 0;
		if (k == 0) begin
			return '0;
		end
		while ((k >> (m + 1)) != 0) begin
			m++;
		end
		x = 64'(k) << (30 - m);
		r = 64'(m) << LOG_FRAC;
		for (b = LOG_FRAC - 1; b >= 0; b--) begin
			x = (x * x) >> 30;
			if (x >= (64'd1 << 31)) begin
				x = x >> 1;
				r = r | (64'd1 << b);
			end
		end
		return LOG_W'(r);
	endfunction

	function automatic log_tab_t build_log_tab();
		log_tab_t t;
		for (int i = 0; i < LOG_ENTRIES; i++) begin
			t[i] = fixed_log2(i);
		end
		return t;
	endfunction

	localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

// File: design/sliding_window_local_entropy.sv
// Local entropy and deviation over a sliding window of a class-valued series. Each accepted
// word is shifted into a row of 2*MAX_HALF_WINDOW+1 cells; every position whose right half has
// arrived (or all pending positions, up to 16, on series_end) then produces one result word.
// A result with a valid centre and enough window samples takes two passes of the window round
// the ring of cells (equal-value counting, then summing log terms), then two restoring
// divisions of one quotient bit per cycle. A not-available result goes from the position
// check or the count test straight to output, and a word that causes no result passes
// only the check and finish states before input is taken again. Input stalls
// while results of the previous word are being computed; one finished result may wait in the
// output register while the next word is taken.
module sliding_window_local_entropy #(
	parameter int MAX_HALF_WINDOW = swle_pkg::MAX_HALF_WINDOW_DEF,
	parameter int SAMPLE_BITS     = swle_pkg::SAMPLE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  swle_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output swle_pkg::out_t out_data,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_data
);

	localparam int DEPTH  = 2 * MAX_HALF_WINDOW + 1;
	localparam int DW     = $clog2(DEPTH);
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int HW     = CW + swle_pkg::LOG_W;
	localparam int DSUM_W = SAMPLE_BITS + CW;
	localparam int NUM_A  = HW + 16;
	localparam int NUM_B  = DSUM_W + 18;
	localparam int NUM_W  = (NUM_A > NUM_B) ? NUM_A : NUM_B;
	localparam int DEN_W  = HW + 1;

	swle_pkg::state_t    state_q, state_d;
	swle_pkg::cell_ctl_t ctl;

	logic [3:0]  half_window_q;
	logic [15:0] num_classes_q;
	logic [4:0]  min_count_q;

	logic [31:0] seen_q, next_pos_q, t_q;
	logic        end_q;
	logic [4:0]  run_cnt_q;
	logic [CW-1:0] step_q;
	logic [CW-1:0] n_q;
	logic [DSUM_W-1:0] dsum_q;
	logic [HW-1:0] sumcl_q, tot_q, den_q, hnum_q;
	logic [CW+15:0] den2_q;
	logic [SAMPLE_BITS-1:0] centre_q;
	logic [15:0] ent_q;
	logic [31:0] dev_q;
	logic        na_q;

	logic        out_valid_q;
	swle_pkg::out_t out_q;

	logic [SAMPLE_BITS-1:0] win_val [DEPTH];
	logic                   win_vld [DEPTH];
	logic [SAMPLE_BITS-1:0] rot_val [DEPTH];
	logic                   rot_mem [DEPTH];
	logic                   c_mem   [DEPTH];
	logic [CW-1:0]          c_cnt   [DEPTH];
	logic [DEPTH-1:0]       member;

	logic [3:0]  h;
	logic [31:0] d, d_next;
	logic [DW-1:0] dl;
	logic        accept, chk_done, chk_na, test_na, out_free, last;
	logic [15:0] ncl;
	logic [CW-1:0] s;
	logic [SAMPLE_BITS-1:0] absdiff;
	logic        div_start, div_busy;
	logic [NUM_W-1:0] div_num, div_quo;
	logic [DEN_W-1:0] div_den;

	assign h = (half_window_q == 4'd0) ? 4'd1 :
		((32'(half_window_q) > 32'(MAX_HALF_WINDOW)) ? 4'(MAX_HALF_WINDOW) : half_window_q);
	assign ncl = (num_classes_q < 16'd2) ? 16'd2 : num_classes_q;
	assign s   = (32'(n_q) > 32'(ncl)) ? CW'(ncl) : n_q;

	assign accept = in_valid && !in_stall;
	assign d      = t_q - next_pos_q;
	assign d_next = d - 32'd1;
	assign dl     = DW'(d);
	assign chk_done = (32'(run_cnt_q) == 32'(swle_pkg::MAX_OUT)) || (seen_q == next_pos_q) ||
		(!end_q && (d < 32'(h)));
	assign chk_na   = (d >= 32'(DEPTH)) ? 1'b1 : !win_vld[dl];
	assign test_na  = (32'(n_q) <= 32'(min_count_q)) || (32'(n_q) < 32'd2);
	assign out_free = !out_valid_q || !out_stall;
	assign last = (32'(run_cnt_q) + 32'd1 == 32'(swle_pkg::MAX_OUT)) ||
		(next_pos_q + 32'd1 == seen_q) || (!end_q && (d_next < 32'(h)));
	assign absdiff = (rot_val[0] > centre_q) ? (rot_val[0] - centre_q) : (centre_q - rot_val[0]);

	// Window membership: within h of the centre and not left of the series start.
	for (genvar i = 0; i < DEPTH; i++) begin : g_mem
		always_comb begin
			if (32'(i) <= 32'(dl)) begin
				member[i] = win_vld[i] && ((32'(dl) - 32'(i)) <= 32'(h));
			end else begin
				member[i] = win_vld[i] && ((32'(i) - 32'(dl)) <= 32'(h)) &&
					((32'(i) - 32'(dl)) <= next_pos_q);
			end
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam int NXT = (i + 1) % DEPTH;
		logic [SAMPLE_BITS-1:0] sh_val;
		logic                   sh_vld;
		if (i == 0) begin : g_head
			assign sh_val = SAMPLE_BITS'(in_data.sample);
			assign sh_vld = in_data.sample_valid;
		end else begin : g_body
			assign sh_val = win_val[i-1];
			assign sh_vld = win_vld[i-1];
		end
		swle_cell #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.CNT_W(CW)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.shift_val(sh_val),
			.shift_vld(sh_vld),
			.member(member[i]),
			.nxt_rot_val(rot_val[NXT]),
			.nxt_rot_mem(rot_mem[NXT]),
			.nxt_mem(c_mem[NXT]),
			.nxt_cnt(c_cnt[NXT]),
			.val(win_val[i]),
			.vld(win_vld[i]),
			.rot_val(rot_val[i]),
			.rot_mem(rot_mem[i]),
			.mem(c_mem[i]),
			.cnt(c_cnt[i])
		);
	end

	swle_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.busy(div_busy),
		.quo(div_quo)
	);

	always_comb begin
		if (state_q == swle_pkg::ST_DIVE_GO) begin
			div_num = NUM_W'({hnum_q, 15'd0}) + NUM_W'(den_q);
			div_den = DEN_W'({den_q, 1'b0});
		end else begin
			div_num = NUM_W'({dsum_q, 17'd0}) + NUM_W'(den2_q);
			div_den = DEN_W'({den2_q, 1'b0});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_window_q <= 4'd1;
			num_classes_q <= 16'd2;
			min_count_q   <= 5'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				swle_pkg::CFG_HALF_WINDOW: half_window_q <= cfg_data[3:0];
				swle_pkg::CFG_NUM_CLASSES: num_classes_q <= cfg_data;
				swle_pkg::CFG_MIN_COUNT:   min_count_q   <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= swle_pkg::ST_IDLE;
			seen_q      <= '0;
			next_pos_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				seen_q <= seen_q + 32'd1;
			end
			if (state_q == swle_pkg::ST_FIN && end_q) begin
				seen_q     <= '0;
				next_pos_q <= '0;
			end
			if (state_q == swle_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
				next_pos_q  <= next_pos_q + 32'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			swle_pkg::ST_IDLE: begin
				t_q       <= seen_q;
				end_q     <= in_data.series_end;
				run_cnt_q <= '0;
			end
			swle_pkg::ST_CHECK: begin
				na_q  <= 1'b1;
				ent_q <= '0;
				dev_q <= '0;
			end
			swle_pkg::ST_LOAD: begin
				centre_q <= win_val[dl];
				step_q   <= '0;
				n_q      <= '0;
				dsum_q   <= '0;
			end
			swle_pkg::ST_ROT: begin
				step_q <= step_q + CW'(1);
				if (rot_mem[0]) begin
					n_q    <= n_q + CW'(1);
					dsum_q <= dsum_q + DSUM_W'(absdiff);
				end
			end
			swle_pkg::ST_TEST: begin
				step_q  <= '0;
				sumcl_q <= '0;
			end
			swle_pkg::ST_SUM: begin
				step_q <= step_q + CW'(1);
				if (c_mem[0]) begin
					sumcl_q <= sumcl_q +
						HW'(swle_pkg::LOG_TAB[swle_pkg::LOG_IDX_W'(c_cnt[0])]);
				end
			end
			swle_pkg::ST_MULA: begin
				tot_q <= HW'(n_q * swle_pkg::LOG_TAB[swle_pkg::LOG_IDX_W'(n_q)]);
				den_q <= HW'(n_q * swle_pkg::LOG_TAB[swle_pkg::LOG_IDX_W'(s)]);
			end
			swle_pkg::ST_MULB: begin
				hnum_q <= (sumcl_q > tot_q) ? '0 : (tot_q - sumcl_q);
				den2_q <= (CW+16)'((n_q - CW'(1)) * (ncl - 16'd1));
			end
			swle_pkg::ST_DIVE_WAIT: begin
				if (!div_busy) begin
					ent_q <= (|div_quo[NUM_W-1:16]) ? 16'hFFFF : div_quo[15:0];
				end
			end
			swle_pkg::ST_DIVD_WAIT: begin
				if (!div_busy) begin
					dev_q <= (|div_quo[NUM_W-1:32]) ? 32'hFFFF_FFFF : div_quo[31:0];
					na_q  <= 1'b0;
				end
			end
			swle_pkg::ST_OUT: begin
				if (out_free) begin
					run_cnt_q                <= run_cnt_q + 5'd1;
					out_q.position      <= next_pos_q;
					out_q.entropy       <= ent_q;
					out_q.deviation     <= dev_q;
					out_q.not_available <= na_q;
					out_q.last_of_run   <= last;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		div_start = 1'b0;
		case (state_q)
			swle_pkg::ST_IDLE: begin
				if (in_valid) begin
					ctl.shift = 1'b1;
					state_d   = swle_pkg::ST_CHECK;
				end
			end
			swle_pkg::ST_CHECK: begin
				if (chk_done) begin
					state_d = swle_pkg::ST_FIN;
				end else if (chk_na) begin
					state_d = swle_pkg::ST_OUT;
				end else begin
					state_d = swle_pkg::ST_LOAD;
				end
			end
			swle_pkg::ST_LOAD: begin
				ctl.load = 1'b1;
				state_d  = swle_pkg::ST_ROT;
			end
			swle_pkg::ST_ROT: begin
				ctl.rot = 1'b1;
				if (32'(step_q) == 32'(DEPTH - 1)) begin
					state_d = swle_pkg::ST_TEST;
				end
			end
			swle_pkg::ST_TEST: begin
				state_d = test_na ? swle_pkg::ST_OUT : swle_pkg::ST_SUM;
			end
			swle_pkg::ST_SUM: begin
				ctl.sum = 1'b1;
				if (32'(step_q) == 32'(DEPTH - 1)) begin
					state_d = swle_pkg::ST_MULA;
				end
			end
			swle_pkg::ST_MULA: state_d = swle_pkg::ST_MULB;
			swle_pkg::ST_MULB: state_d = swle_pkg::ST_DIVE_GO;
			swle_pkg::ST_DIVE_GO: begin
				div_start = 1'b1;
				state_d   = swle_pkg::ST_DIVE_WAIT;
			end
			swle_pkg::ST_DIVE_WAIT: begin
				if (!div_busy) begin
					state_d = swle_pkg::ST_DIVD_GO;
				end
			end
			swle_pkg::ST_DIVD_GO: begin
				div_start = 1'b1;
				state_d   = swle_pkg::ST_DIVD_WAIT;
			end
			swle_pkg::ST_DIVD_WAIT: begin
				if (!div_busy) begin
					state_d = swle_pkg::ST_OUT;
				end
			end
			swle_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = swle_pkg::ST_CHECK;
				end
			end
			swle_pkg::ST_FIN: begin
				ctl.clear = end_q;
				state_d   = swle_pkg::ST_IDLE;
			end
			default: state_d = swle_pkg::ST_IDLE;
		endcase
	end

	assign in_stall  = state_q != swle_pkg::ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(run_cnt_q) <= 32'(swle_pkg::MAX_OUT) || state_q == swle_pkg::ST_IDLE)
		else $error("more results than allowed for one word");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == swle_pkg::ST_CHECK)
		else $error("accepted word not followed by position check");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == swle_pkg::ST_OUT && out_free) |=> out_valid_q)
		else $error("result word not presented after loading");

endmodule

// File: design/swle_cell.sv
module swle_cell #(
	parameter int SAMPLE_BITS = swle_pkg::SAMPLE_BITS_DEF,
	parameter int CNT_W       = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  swle_pkg::cell_ctl_t    ctl,
	input  logic [SAMPLE_BITS-1:0] shift_val,
	input  logic                   shift_vld,
	input  logic                   member,
	input  logic [SAMPLE_BITS-1:0] nxt_rot_val,
	input  logic                   nxt_rot_mem,
	input  logic                   nxt_mem,
	input  logic [CNT_W-1:0]       nxt_cnt,
	output logic [SAMPLE_BITS-1:0] val,
	output logic                   vld,
	output logic [SAMPLE_BITS-1:0] rot_val,
	output logic                   rot_mem,
	output logic                   mem,
	output logic [CNT_W-1:0]       cnt
);

	logic [SAMPLE_BITS-1:0] val_q;
	logic                   vld_q;
	logic [SAMPLE_BITS-1:0] rot_val_q;
	logic                   rot_mem_q;
	logic                   mem_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   hit;

	assign hit = mem_q && rot_mem_q && (rot_val_q == val_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.clear) begin
			vld_q <= 1'b0;
		end else if (ctl.shift) begin
			vld_q <= shift_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			val_q <= shift_val;
		end
		if (ctl.load) begin
			rot_val_q <= val_q;
			rot_mem_q <= member;
			mem_q     <= member;
			cnt_q     <= '0;
		end else if (ctl.rot) begin
			// The travelling word passes on while this cell counts a match against it.
			rot_val_q <= nxt_rot_val;
			rot_mem_q <= nxt_rot_mem;
			if (hit) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end else if (ctl.sum) begin
			mem_q <= nxt_mem;
			cnt_q <= nxt_cnt;
		end
	end

	assign val     = val_q;
	assign vld     = vld_q;
	assign rot_val = rot_val_q;
	assign rot_mem = rot_mem_q;
	assign mem     = mem_q;
	assign cnt     = cnt_q;

endmodule

// File: design/swle_div.sv
module swle_div #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 33
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quo
);

	localparam int CW = $clog2(NUM_W + 1);

	logic [CW-1:0]    cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NUM_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			// Remainder stays below the divisor, so it fits DEN_W bits after the subtract.
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign busy = cnt_q != '0;
	assign quo  = quo_q;

endmodule
